// ----- rtl/core/uart_line_framer_unit_defines.svh -----
// Assertion macros shared by the line framer checker.
`ifndef UART_LINE_FRAMER_UNIT_DEFINES_SVH
`define UART_LINE_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication under a synchronous reset.
`define ULF_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("line framer check failed");

// Next-cycle implication under a synchronous reset.
`define ULF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("line framer check failed");

`endif

// ----- rtl/core/ulf_pkg.sv -----
// Shared constants for the UART line framer.
`default_nettype none
package ulf_pkg;
   localparam int BUFFER_SIZE = 32;
   localparam int ADDR_W = $clog2(BUFFER_SIZE);

   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] FRAME_S = 8'h53;
   localparam logic [7:0] FRAME_I = 8'h49;
   localparam logic [7:0] PREFIX_EXTRA = 8'd3;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_POLL = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/core/ulf_ram.sv -----
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module ulf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/core/uart_line_framer_unit.sv -----
// Top level of the UART line framer: line store, completeness check and line readout.
`default_nettype none
// A received byte is accepted and gives no item on the response side.
// A poll with no complete line gives one not-found item in the cycle after it is
// accepted. A poll that finds a line of n bytes goes through ST_READ and then ST_EMIT
// for every byte: a read of the single line store port and then a load of the response
// register; requests are held off during that readout and whenever a response waits.
module uart_line_framer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_line_found,
   output logic      [7:0] rsp_line_byte,
   output logic            rsp_last
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam int AW = ulf_pkg::ADDR_W;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] len_ff, len_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    third_ff, third_in;
   logic [7:0]    recent_ff, recent_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_accept;
   logic          out_free;
   logic          complete;
   logic          exempt_s;
   logic          exempt_i;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [7:0]    rd_data;

   assign exempt_s = (first_ff == ulf_pkg::FRAME_S) &&
                     ((pos_ff < AW'(2)) ||
                      (9'(pos_ff) < (9'(third_ff) + 9'(ulf_pkg::PREFIX_EXTRA))));
   assign exempt_i = (first_ff == ulf_pkg::FRAME_I) && (pos_ff < AW'(2));
   assign complete = (pos_ff != '0) && (recent_ff == ulf_pkg::NEWLINE_CODE) &&
                     !exempt_s && !exempt_i;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign wr_addr = complete ? '0 : pos_ff;

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      first_in = first_ff;
      third_in = third_ff;
      recent_in = recent_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      wr_en = 1'b0;
      rd_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_operation == ulf_pkg::OP_RECEIVE) begin
                  wr_en = 1'b1;
                  recent_in = req_rx_byte;
                  if (wr_addr == AW'(0)) begin
                     first_in = req_rx_byte;
                  end
                  if (wr_addr == AW'(2)) begin
                     third_in = req_rx_byte;
                  end
                  pos_in = (wr_addr == AW'(ulf_pkg::BUFFER_SIZE - 1)) ? '0 : wr_addr + 1'b1;
               end else if (complete) begin
                  len_in = pos_ff;
                  idx_in = '0;
                  pos_in = '0;
                  state_in = ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_byte_in = 8'd0;
                  rsp_last_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            rd_en = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_byte_in = rd_data;
               rsp_last_in = (idx_ff == len_ff - 1'b1);
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff == len_ff - 1'b1) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         first_ff <= 8'd0;
         third_ff <= 8'd0;
         recent_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         first_ff <= first_in;
         third_ff <= third_in;
         recent_ff <= recent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      len_ff <= len_in;
      rsp_found_ff <= rsp_found_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   ulf_ram #(
      .WIDTH(8),
      .DEPTH(ulf_pkg::BUFFER_SIZE)
   ) line_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_rx_byte),
      .rd_en  (rd_en),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_line_found = rsp_found_ff;
   assign rsp_line_byte = rsp_byte_ff;
   assign rsp_last = rsp_last_ff;
endmodule
`default_nettype wire

// ----- rtl/core/ulf_checker.sv -----
// Port-level assertions for the UART line framer and their bind.
`default_nettype none
`include "uart_line_framer_unit_defines.svh"
module ulf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       req_operation,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_line_found,
   input wire logic [7:0] rsp_line_byte,
   input wire logic       rsp_last
);
   logic req_take;
   logic rsp_hold;
   logic poll_take;
   logic rx_take_quiet;
   logic not_found_ok;

   assign req_take = req_valid && !req_stall;
   assign rsp_hold = rsp_valid && rsp_stall;
   assign poll_take = req_take && (req_operation == ulf_pkg::OP_POLL);
   assign rx_take_quiet = req_take && !rsp_valid && (req_operation == ulf_pkg::OP_RECEIVE);
   assign not_found_ok = rsp_last && (rsp_line_byte == 8'd0);

   `ULF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_hold, rsp_valid)
   `ULF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_hold, $stable(rsp_line_byte))
   `ULF_ASSERT_NOW(a_not_found_shape, clock, reset, rsp_valid && !rsp_line_found, not_found_ok)
   `ULF_ASSERT_NEXT(a_poll_answers, clock, reset, poll_take, rsp_valid || req_stall)
   `ULF_ASSERT_NEXT(a_receive_silent, clock, reset, rx_take_quiet, !rsp_valid)
endmodule

bind uart_line_framer_unit ulf_checker u_ulf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_line_found(rsp_line_found),
   .rsp_line_byte (rsp_line_byte),
   .rsp_last      (rsp_last)
);
`default_nettype wire

// ----- tb/line_framer_checker.sv -----
// Checker for the UART line framer: predicts response items and compares them.
module line_framer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_line_found,
   input  logic [7:0] rsp_line_byte,
   input  logic       rsp_last,
   output int         failures,
   output int         pending,
   output int         checked
);

   typedef struct packed {
      logic       found;
      logic [7:0] data;
      logic       last;
   } line_item_type;

   logic [7:0]    line_mem [ulf_pkg::BUFFER_SIZE];
   int unsigned   wr_pos;
   line_item_type expected_line_q [$];
   int            fail_n;
   int            checked_n;

   function automatic bit line_is_complete();
      int unsigned prefix_end;
      if (wr_pos == 0 || wr_pos > ulf_pkg::BUFFER_SIZE) return 1'b0;
      if (line_mem[wr_pos - 1] != ulf_pkg::NEWLINE_CODE) return 1'b0;
      prefix_end = line_mem[2];
      prefix_end = prefix_end + ulf_pkg::PREFIX_EXTRA;
      if (line_mem[0] == ulf_pkg::FRAME_S && (wr_pos < 2 || wr_pos < prefix_end)) return 1'b0;
      if (line_mem[0] == ulf_pkg::FRAME_I && wr_pos < 2) return 1'b0;
      return 1'b1;
   endfunction

   initial begin
      fail_n = 0;
      checked_n = 0;
      wr_pos = 0;
      failures = 0;
      pending = 0;
      checked = 0;
   end

   always @(posedge clock) begin
      line_item_type want;
      if (reset) begin
         for (int i = 0; i < ulf_pkg::BUFFER_SIZE; i++) line_mem[i] = 8'h00;
         wr_pos = 0;
         expected_line_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_n++;
            if (expected_line_q.size() == 0) begin
               $error("Unexpected response item: line_found=%0d line_byte=%02h last=%0d",
                      rsp_line_found, rsp_line_byte, rsp_last);
               fail_n++;
            end else begin
               want = expected_line_q.pop_front();
               if (rsp_line_found !== want.found) begin
                  $error("line_found mismatch: expected %0d, actual %0d",
                         want.found, rsp_line_found);
                  fail_n++;
               end
               if (rsp_line_byte !== want.data) begin
                  $error("line_byte mismatch: expected %02h, actual %02h",
                         want.data, rsp_line_byte);
                  fail_n++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
                  fail_n++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_operation == ulf_pkg::OP_RECEIVE) begin
               if (line_is_complete()) wr_pos = 0;
               if (wr_pos >= ulf_pkg::BUFFER_SIZE) wr_pos = 0;
               line_mem[wr_pos] = req_rx_byte;
               wr_pos++;
               if (wr_pos >= ulf_pkg::BUFFER_SIZE) wr_pos = 0;
            end else if (line_is_complete()) begin
               for (int k = 0; k < wr_pos; k++) begin
                  expected_line_q.push_back('{found: 1'b1, data: line_mem[k],
                                              last: (k + 1 == wr_pos)});
               end
               wr_pos = 0;
            end else begin
               expected_line_q.push_back('{found: 1'b0, data: 8'h00, last: 1'b1});
            end
         end
      end
      pending <= expected_line_q.size();
      failures <= fail_n;
      checked <= checked_n;
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the UART line framer testbench: clock, reset, stimulus and verdict.
module testbench;

   localparam int RANDOM_ITEMS = 320;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = ulf_pkg::OP_RECEIVE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_line_found;
   logic [7:0] rsp_line_byte;
   logic       rsp_last;

   int failures;
   int pending;
   int checked;
   bit no_idle = 1'b0;
   int sent_rx = 0;
   int sent_poll = 0;

   always #10 clock = ~clock;

   uart_line_framer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_line_found(rsp_line_found),
      .rsp_line_byte(rsp_line_byte),
      .rsp_last(rsp_last)
   );

   line_framer_checker line_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_line_found(rsp_line_found),
      .rsp_line_byte(rsp_line_byte),
      .rsp_last(rsp_last),
      .failures(failures),
      .pending(pending),
      .checked(checked)
   );

   task automatic send_item(input logic op, input logic [7:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_rx_byte <= data;
      do @(posedge clock); while (req_stall);
      if (op == ulf_pkg::OP_POLL) sent_poll++;
      else sent_rx++;
   endtask

   task automatic receive(input logic [7:0] data);
      send_item(ulf_pkg::OP_RECEIVE, data);
   endtask

   task automatic poll();
      send_item(ulf_pkg::OP_POLL, 8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == ulf_pkg::NEWLINE_CODE) b = 8'h8A;
      return b;
   endfunction

   task automatic random_frame(input int seq);
      int kind;
      int len;
      int plen;
      kind = (seq == 0) ? 0 : $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            if (seq == 0) len = ulf_pkg::BUFFER_SIZE - 2;
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, ulf_pkg::BUFFER_SIZE - 2);
            else len = $urandom_range(0, 8);
            repeat (len) receive(text_byte());
            receive(ulf_pkg::NEWLINE_CODE);
            if (seq == 0 || $urandom_range(0, 3) != 0) poll();
         end
         4, 5: begin
            if ($urandom_range(0, 4) == 0) plen = $urandom_range(0, 255);
            else plen = $urandom_range(0, 12);
            len = $urandom_range(0, 20);
            receive(ulf_pkg::FRAME_S);
            receive(text_byte());
            receive(8'(plen));
            repeat (len) begin
               receive(($urandom_range(0, 5) == 0) ? ulf_pkg::NEWLINE_CODE : text_byte());
            end
            if ($urandom_range(0, 1) == 1) poll();
            receive(ulf_pkg::NEWLINE_CODE);
            poll();
         end
         6: begin
            receive(ulf_pkg::FRAME_I);
            repeat ($urandom_range(0, 6)) receive(text_byte());
            receive(ulf_pkg::NEWLINE_CODE);
            poll();
         end
         7: begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 3) == 0) receive(ulf_pkg::NEWLINE_CODE);
               else receive(8'($urandom_range(0, 255)));
               if ($urandom_range(0, 2) == 0) poll();
            end
         end
         8: begin
            poll();
            if ($urandom_range(0, 1) == 1) poll();
         end
         default: begin
            repeat ($urandom_range(ulf_pkg::BUFFER_SIZE, ulf_pkg::BUFFER_SIZE + 8)) begin
               receive(text_byte());
            end
            if ($urandom_range(0, 1) == 1) receive(ulf_pkg::NEWLINE_CODE);
            poll();
         end
      endcase
   endtask

   initial begin
      #20000000;
      $display("Run timed out before all response items arrived.");
      $display("FAILURE");
      $finish;
   end

   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int target;
      int seq;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      poll();
      receive(ulf_pkg::NEWLINE_CODE);
      poll();
      receive(8'h00);
      receive(8'hFF);
      receive(ulf_pkg::NEWLINE_CODE);
      poll();
      // The length prefix holds the line back until it reaches prefix plus three bytes.
      receive(ulf_pkg::FRAME_S);
      receive(8'h01);
      receive(8'h02);
      receive(ulf_pkg::NEWLINE_CODE);
      poll();
      receive(ulf_pkg::NEWLINE_CODE);
      poll();
      receive(ulf_pkg::FRAME_I);
      receive(ulf_pkg::NEWLINE_CODE);
      poll();
      // A byte that arrives after a complete line starts a new one.
      receive("x");
      receive(ulf_pkg::NEWLINE_CODE);
      receive("y");
      receive(ulf_pkg::NEWLINE_CODE);
      poll();
      drain();

      target = sent_rx + sent_poll + RANDOM_ITEMS;
      seq = 0;
      while (sent_rx + sent_poll < target) begin
         no_idle = (seq != 0) && ($urandom_range(0, 7) == 0);
         random_frame(seq);
         if (seq == 40 || $urandom_range(0, 29) == 0) drain();
         seq++;
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (70) @(posedge clock);
      $display("Sent %0d received bytes and %0d polls; %0d response items were checked.",
               sent_rx, sent_poll, checked);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
